[hw/rtl/lkrc_pkg.sv]
package lkrc_pkg;

  // Table geometry
  localparam int ENTRIES      = 256;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);

  // Fixed field widths of the ports
  localparam int ACT_W     = 2;
  localparam int KEY_W     = 64;
  localparam int GEN_W     = 32;
  localparam int OUT_PAY_W = 32;
  localparam int CAP_W     = 9;
  localparam int OCC_W     = 9;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_PUT    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_TRIM   = 2'd3
  } action_t;

  typedef struct packed {
    action_t                action;
    logic [KEY_W-1:0]       key;
    logic [GEN_W-1:0]       generation;
    logic [OUT_PAY_W-1:0]   payload;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic                   stale;
    logic [OUT_PAY_W-1:0]   hit_payload;
    logic                   evicted;
    logic [KEY_W-1:0]       evicted_key;
    logic [OCC_W-1:0]       evict_count;
    logic [OCC_W-1:0]       occupancy;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_ADJ,
    ST_RESP
  } state_t;

  typedef enum logic {
    MODE_PROMOTE,
    MODE_DROP
  } sweep_mode_t;

endpackage

[hw/rtl/lkrc_req_if.sv]
interface lkrc_req_if;
  logic               valid;
  logic               ready;
  lkrc_pkg::req_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/lkrc_rsp_if.sv]
interface lkrc_rsp_if;
  logic               valid;
  logic               ready;
  lkrc_pkg::rsp_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/lkrc_cfg_if.sv]
interface lkrc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lkrc_pkg::CAP_W-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/lru_keyed_result_cache_unit.sv]
// A lookup hit, or a put that updates, replaces or overflows, scans the table and then runs a rank adjust
// sweep; other lookups and puts only scan, a trim sweeps only when it removes entries, a clear does not sweep.
// Throughput: one item at a time; no new request is taken until the result beat of the
// last one is loaded. Each sweep reads the entry memories one entry per cycle.
// Reset (synchronous, rst high): table empty, all valid marks cleared at once, capacity 256;
// entry memories keep their contents and are only read behind a valid mark.
module lru_keyed_result_cache_unit (
  input  logic        clk,
  input  logic        rst,
  lkrc_cfg_if.sink    cfg,
  lkrc_req_if.sink    req,
  lkrc_rsp_if.source  rsp
);

  localparam int IDX_W = lkrc_pkg::IDX_W;
  localparam int CNT_W = lkrc_pkg::CNT_W;
  localparam int CMP_W = lkrc_pkg::CMP_W;
  localparam int KEY_W = lkrc_pkg::KEY_W;
  localparam int GEN_W = lkrc_pkg::GEN_W;
  localparam int PAY_W = lkrc_pkg::PAYLOAD_BITS;

  // ---------------------------------------------------------------------------
  // Entry storage: four memories, each with one write port and one registered read port,
  // plus a flop per entry for the valid mark.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] mem_key  [lkrc_pkg::ENTRIES];
  logic [GEN_W-1:0] mem_gen  [lkrc_pkg::ENTRIES];
  logic [PAY_W-1:0] mem_pay  [lkrc_pkg::ENTRIES];
  logic [IDX_W-1:0] mem_rank [lkrc_pkg::ENTRIES];

  logic [KEY_W-1:0] key_q;
  logic [GEN_W-1:0] gen_q;
  logic [PAY_W-1:0] pay_q;
  logic [IDX_W-1:0] rank_q;

  logic [lkrc_pkg::ENTRIES-1:0] entry_valid;

  // Control state
  lkrc_pkg::state_t state, state_next;
  logic [CNT_W-1:0] rd_cnt;   // sweep read pointer, reaches ENTRIES at the end
  logic             pv;       // read data of entry pidx is on key_q..rank_q
  logic [IDX_W-1:0] pidx;
  logic [lkrc_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0] live;

  // Latched item
  lkrc_pkg::action_t act;
  logic [KEY_W-1:0] key_r;
  logic [GEN_W-1:0] gen_r;
  logic [PAY_W-1:0] pay_r;

  // Scan findings
  logic             found;
  logic [IDX_W-1:0] fslot;
  logic [IDX_W-1:0] frank;
  logic [GEN_W-1:0] fgen;
  logic [PAY_W-1:0] fpay;
  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] old_slot;
  logic [KEY_W-1:0] old_key;

  // Adjust sweep setup
  lkrc_pkg::sweep_mode_t mode;
  logic [IDX_W-1:0] tgt;
  logic [IDX_W-1:0] thr;
  logic [CNT_W-1:0] cut;

  // Result fields in progress and the output register
  logic                       res_hit;
  logic                       res_stale;
  logic [lkrc_pkg::OUT_PAY_W-1:0] res_hp;
  logic                       res_ev;
  logic [KEY_W-1:0]           res_evk;
  logic [CNT_W-1:0]           res_cnt;
  logic                       rsp_valid;
  lkrc_pkg::rsp_t             rsp_data;

  // ---------------------------------------------------------------------------
  // Shared arithmetic: capacity bound and sweep bookkeeping
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] cap_ext, ent_ext, eff_cap, live_ext;
  logic             trim_go;
  logic [CNT_W-1:0] trim_n;
  logic [CNT_W-1:0] live_inc;
  logic             over_after_ins;
  logic             is_full;
  logic             in_sweep;
  logic             sweep_rd;
  logic             vld_p;
  logic             last_p;
  logic             req_fire;
  logic             rsp_load;

  assign cap_ext  = CMP_W'(capacity);
  assign ent_ext  = CMP_W'(lkrc_pkg::ENTRIES);
  // Zero capacity means no cap; anything above the table size saturates.
  assign eff_cap  = (capacity == '0 || cap_ext > ent_ext) ? ent_ext : cap_ext;
  assign live_ext = CMP_W'(live);
  assign trim_go  = (capacity != '0) && (live_ext > eff_cap);
  assign trim_n   = CNT_W'(live_ext - eff_cap);
  assign live_inc = live + CNT_W'(1);
  assign over_after_ins = (capacity != '0) && (CMP_W'(live_inc) > eff_cap);
  assign is_full  = (live == CNT_W'(lkrc_pkg::ENTRIES));

  assign in_sweep = (state == lkrc_pkg::ST_SCAN) || (state == lkrc_pkg::ST_ADJ);
  assign sweep_rd = rd_cnt < CNT_W'(lkrc_pkg::ENTRIES);
  assign vld_p    = entry_valid[pidx];
  assign last_p   = pv && (pidx == IDX_W'(lkrc_pkg::ENTRIES - 1));

  assign req.ready = (state == lkrc_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // ---------------------------------------------------------------------------
  // Decision and write control
  // ---------------------------------------------------------------------------
  logic             wr_key_en, wr_dat_en, wr_rank_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_rank;
  logic             clr_valid;
  logic             dec_adj, dec_hit, dec_stale, dec_ev, dec_ins;
  lkrc_pkg::sweep_mode_t dec_mode;
  logic [IDX_W-1:0] dec_tgt, dec_thr;
  logic [CNT_W-1:0] dec_cut;

  always_comb begin
    wr_key_en  = 1'b0;
    wr_dat_en  = 1'b0;
    wr_rank_en = 1'b0;
    wr_addr    = pidx;
    wr_rank    = rank_q;
    clr_valid  = 1'b0;
    dec_adj    = 1'b0;
    dec_hit    = 1'b0;
    dec_stale  = 1'b0;
    dec_ev     = 1'b0;
    dec_ins    = 1'b0;
    dec_mode   = lkrc_pkg::MODE_PROMOTE;
    dec_tgt    = fslot;
    dec_thr    = frank;
    dec_cut    = CNT_W'(1);
    case (state)
      lkrc_pkg::ST_DECIDE: begin
        case (act)
          lkrc_pkg::ACT_LOOKUP: begin
            // Matching generation: hit and promote. Otherwise leave a stale entry alone.
            if (found && fgen == gen_r) begin
              dec_hit = 1'b1;
              dec_adj = 1'b1;
            end else if (found) begin
              dec_stale = 1'b1;
            end
          end
          lkrc_pkg::ACT_PUT: begin
            if (found) begin
              // Overwrite in place and promote.
              wr_addr   = fslot;
              wr_dat_en = 1'b1;
              dec_adj   = 1'b1;
            end else if (is_full) begin
              // Replace the least recent entry; promoting it from rank zero
              // shifts every other rank down exactly as an eviction would.
              dec_ev    = 1'b1;
              wr_addr   = old_slot;
              wr_key_en = 1'b1;
              wr_dat_en = 1'b1;
              dec_adj   = 1'b1;
              dec_tgt   = old_slot;
              dec_thr   = '0;
            end else begin
              // Insert as most recent at the first free slot.
              wr_addr    = free_slot;
              wr_key_en  = 1'b1;
              wr_dat_en  = 1'b1;
              wr_rank_en = 1'b1;
              wr_rank    = IDX_W'(live);
              dec_ins    = 1'b1;
              if (over_after_ins) begin
                // Over capacity: drop one least recent entry.
                dec_ev   = 1'b1;
                dec_adj  = 1'b1;
                dec_mode = lkrc_pkg::MODE_DROP;
              end
            end
          end
          default: begin
          end
        endcase
      end
      lkrc_pkg::ST_ADJ: begin
        if (pv && vld_p) begin
          case (mode)
            lkrc_pkg::MODE_PROMOTE: begin
              if (pidx == tgt) begin
                wr_rank_en = 1'b1;
                wr_rank    = IDX_W'(live - CNT_W'(1));
              end else if (rank_q > thr) begin
                wr_rank_en = 1'b1;
                wr_rank    = rank_q - IDX_W'(1);
              end
            end
            lkrc_pkg::MODE_DROP: begin
              // Drop the cut oldest entries in one pass, shift the rest down.
              if (CNT_W'(rank_q) < cut) begin
                clr_valid = 1'b1;
              end else begin
                wr_rank_en = 1'b1;
                wr_rank    = rank_q - IDX_W'(cut);
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      lkrc_pkg::ST_IDLE: begin
        if (req.valid) begin
          case (req.data.action)
            lkrc_pkg::ACT_CLEAR: state_next = lkrc_pkg::ST_RESP;
            lkrc_pkg::ACT_TRIM:  state_next = trim_go ? lkrc_pkg::ST_ADJ : lkrc_pkg::ST_RESP;
            default:             state_next = lkrc_pkg::ST_SCAN;
          endcase
        end
      end
      lkrc_pkg::ST_SCAN: begin
        if (last_p) state_next = lkrc_pkg::ST_DECIDE;
      end
      lkrc_pkg::ST_DECIDE: begin
        state_next = dec_adj ? lkrc_pkg::ST_ADJ : lkrc_pkg::ST_RESP;
      end
      lkrc_pkg::ST_ADJ: begin
        if (last_p) state_next = lkrc_pkg::ST_RESP;
      end
      lkrc_pkg::ST_RESP: begin
        if (rsp_load) state_next = lkrc_pkg::ST_IDLE;
      end
      default: state_next = lkrc_pkg::ST_IDLE;
    endcase
  end

  // Load the result beat once the output register is free or being drained.
  assign rsp_load = (state == lkrc_pkg::ST_RESP) && (!rsp_valid || rsp.ready);

  // ---------------------------------------------------------------------------
  // Memories: one write and one registered read per cycle each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_key_en)  mem_key[wr_addr]  <= key_r;
    if (wr_dat_en) begin
      mem_gen[wr_addr] <= gen_r;
      mem_pay[wr_addr] <= pay_r;
    end
    if (wr_rank_en) mem_rank[wr_addr] <= wr_rank;
    key_q  <= mem_key[IDX_W'(rd_cnt)];
    gen_q  <= mem_gen[IDX_W'(rd_cnt)];
    pay_q  <= mem_pay[IDX_W'(rd_cnt)];
    rank_q <= mem_rank[IDX_W'(rd_cnt)];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lkrc_pkg::ST_IDLE;
      capacity    <= lkrc_pkg::CAP_RESET;
      live        <= '0;
      entry_valid <= '0;
      rd_cnt      <= '0;
      pv          <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) capacity <= cfg.data;

      // Advance the sweep pointer; park it at zero outside the sweeps.
      if (in_sweep) begin
        if (sweep_rd) rd_cnt <= rd_cnt + CNT_W'(1);
      end else begin
        rd_cnt <= '0;
      end
      pv <= in_sweep && sweep_rd;

      if (req_fire) begin
        case (req.data.action)
          lkrc_pkg::ACT_CLEAR: begin
            entry_valid <= '0;
            live        <= '0;
          end
          lkrc_pkg::ACT_TRIM: begin
            if (trim_go) live <= live - trim_n;
          end
          default: begin
          end
        endcase
      end

      if (state == lkrc_pkg::ST_DECIDE && dec_ins) begin
        entry_valid[free_slot] <= 1'b1;
        // An insert that overflows the capacity drops one entry again.
        if (!over_after_ins) live <= live_inc;
      end

      if (clr_valid) entry_valid[pidx] <= 1'b0;

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    pidx <= IDX_W'(rd_cnt);

    if (req_fire) begin
      act       <= req.data.action;
      key_r     <= req.data.key;
      gen_r     <= req.data.generation;
      pay_r     <= PAY_W'(req.data.payload);
      found     <= 1'b0;
      res_hit   <= 1'b0;
      res_stale <= 1'b0;
      res_hp    <= '0;
      res_ev    <= 1'b0;
      res_evk   <= '0;
      res_cnt   <= '0;
      mode      <= lkrc_pkg::MODE_DROP;
      cut       <= trim_n;
      if (req.data.action == lkrc_pkg::ACT_TRIM && trim_go) res_cnt <= trim_n;
    end

    // Scan: one key compare per cycle; note the first free slot and the oldest entry.
    if (state == lkrc_pkg::ST_SCAN && pv) begin
      if (vld_p && key_q == key_r) begin
        found <= 1'b1;
        fslot <= pidx;
        frank <= rank_q;
        fgen  <= gen_q;
        fpay  <= pay_q;
      end
      if (!vld_p && free_slot_first) free_slot <= pidx;
      if (vld_p && rank_q == '0) begin
        old_slot <= pidx;
        old_key  <= key_q;
      end
    end

    if (state == lkrc_pkg::ST_DECIDE) begin
      mode      <= dec_mode;
      tgt       <= dec_tgt;
      thr       <= dec_thr;
      cut       <= dec_cut;
      res_hit   <= dec_hit;
      res_stale <= dec_stale;
      res_hp    <= dec_hit ? lkrc_pkg::OUT_PAY_W'(fpay) : '0;
      res_ev    <= dec_ev;
      res_evk   <= dec_ev ? old_key : '0;
    end

    if (rsp_load) begin
      rsp_data.hit         <= res_hit;
      rsp_data.stale       <= res_stale;
      rsp_data.hit_payload <= res_hp;
      rsp_data.evicted     <= res_ev;
      rsp_data.evicted_key <= res_evk;
      rsp_data.evict_count <= lkrc_pkg::OCC_W'(res_cnt);
      rsp_data.occupancy   <= lkrc_pkg::OCC_W'(live);
    end
  end

  // Track whether a free slot was seen yet in this scan.
  logic free_seen;
  logic free_slot_first;
  assign free_slot_first = !free_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_seen <= 1'b0;
    end else if (req_fire) begin
      free_seen <= 1'b0;
    end else if (state == lkrc_pkg::ST_SCAN && pv && !vld_p) begin
      free_seen <= 1'b1;
    end
  end

endmodule

[verif/tb_top.sv]
module tb_top;
  import lkrc_pkg::*;

  // Generous cycle budget: every item as a full double sweep plus stalls, several times over.
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
  localparam int HIST_DEPTH   = 512;
  localparam int NUM_PHASES   = 6;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One row of the directed table: either a capacity write or a request,
  // with a hand-written result where it is obvious.
  typedef struct {
    bit                 is_cfg;
    logic [CAP_W-1:0]   cap;
    req_t               item;
    bit                 typed;
    rsp_t               want;
  } dir_row_t;

  typedef struct {
    logic [CAP_W-1:0]   cap;
    idle_mode_t         mode;
    int                 items;
    int                 put_pct;
    int                 trim_pct;
    int                 clear_pct;
  } phase_t;

  logic clk;
  logic rst;

  lkrc_cfg_if cfg_ch ();
  lkrc_req_if req_ch ();
  lkrc_rsp_if rsp_ch ();

  lru_keyed_result_cache_unit u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the cache table; age 0 is the least recently used entry.
  bit               slot_used [ENTRIES];
  logic [KEY_W-1:0] slot_key  [ENTRIES];
  logic [GEN_W-1:0] slot_gen  [ENTRIES];
  logic [OUT_PAY_W-1:0] slot_pay [ENTRIES];
  int unsigned      slot_age  [ENTRIES];
  int unsigned      live;
  logic [CAP_W-1:0] cap_reg;

  rsp_t             pending_results [$];
  bit               failed;
  int               send_idle_pct;
  int               recv_stall_pct;
  int unsigned      cycles;

  // Recently put keys, so lookups and re-puts find live entries.
  logic [KEY_W-1:0] key_hist [HIST_DEPTH];
  int               hist_n;
  logic [GEN_W-1:0] gen_pool [2];

  dir_row_t         directed [$];
  phase_t           phases [NUM_PHASES];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung block.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Response-side backpressure; one draw per cycle.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // Move slot s to most recent; close the gap above its old age.
  function automatic void make_newest(int s);
    int unsigned old_age;
    old_age = slot_age[s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_age[i] > old_age) slot_age[i]--;
    slot_age[s] = live - 1;
  endfunction

  // Drop the least recent entry and return its slot, -1 if none.
  function automatic int drop_oldest();
    int s;
    s = -1;
    if (live == 0) return -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_age[i] == 0) begin
        s = i;
        break;
      end
    if (s < 0) return -1;
    slot_used[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i]) slot_age[i]--;
    live--;
    return s;
  endfunction

  // Zero means no cap; anything above the table size saturates to it.
  function automatic int unsigned cap_limit();
    if (cap_reg == 0 || cap_reg > ENTRIES) return ENTRIES;
    return cap_reg;
  endfunction

  function automatic rsp_t predict_cache_result(req_t r);
    rsp_t        o;
    int          s;
    int unsigned removed;
    o = '0;
    removed = 0;
    case (r.action)
      ACT_LOOKUP: begin
        s = find_slot(r.key);
        if (s >= 0) begin
          if (slot_gen[s] == r.generation) begin
            o.hit = 1'b1;
            o.hit_payload = slot_pay[s];
            make_newest(s);
          end else begin
            // stale: report only, keep its place
            o.stale = 1'b1;
          end
        end
      end
      ACT_PUT: begin
        s = find_slot(r.key);
        if (s >= 0) begin
          slot_gen[s] = r.generation;
          slot_pay[s] = r.payload;
          make_newest(s);
        end else begin
          // full table: make room first
          if (live >= ENTRIES) begin
            s = drop_oldest();
            if (s >= 0) begin
              o.evicted = 1'b1;
              o.evicted_key = slot_key[s];
            end
          end
          s = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (!slot_used[i]) begin
              s = i;
              break;
            end
          if (s >= 0) begin
            slot_used[s] = 1'b1;
            slot_key[s] = r.key;
            slot_gen[s] = r.generation;
            slot_pay[s] = r.payload;
            slot_age[s] = live;
            live++;
            // over capacity: at most one eviction per put
            if (!o.evicted && cap_reg != 0 && live > cap_limit()) begin
              s = drop_oldest();
              if (s >= 0) begin
                o.evicted = 1'b1;
                o.evicted_key = slot_key[s];
              end
            end
          end
        end
      end
      ACT_CLEAR: begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        live = 0;
      end
      ACT_TRIM: begin
        if (cap_reg != 0)
          while (live > cap_limit()) begin
            if (drop_oldest() < 0) break;
            removed++;
          end
      end
    endcase
    o.evict_count = OCC_W'(removed);
    o.occupancy = OCC_W'(live);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rsp_t result_of(bit h, bit st, logic [OUT_PAY_W-1:0] hp, bit ev,
                                     logic [KEY_W-1:0] evk, logic [OCC_W-1:0] cnt,
                                     logic [OCC_W-1:0] occ);
    rsp_t o;
    o.hit = h;
    o.stale = st;
    o.hit_payload = hp;
    o.evicted = ev;
    o.evicted_key = evk;
    o.evict_count = cnt;
    o.occupancy = occ;
    return o;
  endfunction

  function automatic dir_row_t op_row(action_t a, logic [KEY_W-1:0] k, logic [GEN_W-1:0] g,
                                      logic [OUT_PAY_W-1:0] p, bit typed, rsp_t want);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cap = '0;
    row.item.action = a;
    row.item.key = k;
    row.item.generation = g;
    row.item.payload = p;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t cap_row(logic [CAP_W-1:0] c);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.cap = c;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic logic [KEY_W-1:0] recent_key();
    int span;
    int off;
    span = (hist_n < 300) ? hist_n : 300;
    off = $urandom_range(0, span - 1);
    return key_hist[(hist_n - 1 - off) % HIST_DEPTH];
  endfunction

  // Mostly well-formed traffic on live keys, with a few stray keys and generations.
  function automatic req_t random_request(int put_pct, int trim_pct, int clear_pct);
    req_t r;
    int   roll;
    roll = $urandom_range(0, 99);
    r.key = {$urandom, $urandom};
    r.generation = ($urandom_range(0, 9) == 0) ? $urandom : gen_pool[$urandom_range(0, 1)];
    r.payload = $urandom;
    if (roll < clear_pct) begin
      r.action = ACT_CLEAR;
    end else if (roll < clear_pct + trim_pct) begin
      r.action = ACT_TRIM;
    end else if (roll < clear_pct + trim_pct + put_pct) begin
      r.action = ACT_PUT;
      if (hist_n > 0 && $urandom_range(0, 99) < 15) begin
        r.key = recent_key();
      end else begin
        key_hist[hist_n % HIST_DEPTH] = r.key;
        hist_n++;
      end
    end else begin
      r.action = ACT_LOOKUP;
      if (hist_n > 0 && $urandom_range(0, 99) < 85) r.key = recent_key();
    end
    return r;
  endfunction

  // Drive one request beat, hold until accepted, then queue what it should return.
  task automatic send_request(req_t r, bit typed, rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_cache_result(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold until every queued result beat has come back.
  task automatic wait_results_done();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg = c;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, got.hit);
        check_field("stale", want.stale, got.stale);
        check_field("hit_payload", want.hit_payload, got.hit_payload);
        check_field("evicted", want.evicted, got.evicted);
        check_field("evicted_key", want.evicted_key, got.evicted_key);
        check_field("evict_count", want.evict_count, got.evict_count);
        check_field("occupancy", want.occupancy, got.occupancy);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    failed = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hist_n = 0;
    live = 0;
    cap_reg = CAP_RESET;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    gen_pool[0] = $urandom;
    gen_pool[1] = $urandom;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;

    // Directed table: reset state, field extremes, hit/stale/miss, update of a
    // live key, capacity eviction, trim with and without a cap, clear, saturation.
    directed.push_back(op_row(ACT_LOOKUP, '0, '0, '0, 1, result_of(0, 0, 0, 0, 0, 0, 0)));
    directed.push_back(op_row(ACT_TRIM, '0, '0, '0, 1, result_of(0, 0, 0, 0, 0, 0, 0)));
    directed.push_back(op_row(ACT_PUT, '0, '0, '0, 1, result_of(0, 0, 0, 0, 0, 0, 1)));
    directed.push_back(op_row(ACT_PUT, '1, '1, '1, 1, result_of(0, 0, 0, 0, 0, 0, 2)));
    directed.push_back(op_row(ACT_LOOKUP, '1, '1, '0, 1,
                              result_of(1, 0, 32'hFFFF_FFFF, 0, 0, 0, 2)));
    directed.push_back(op_row(ACT_LOOKUP, '1, '0, '0, 1, result_of(0, 1, 0, 0, 0, 0, 2)));
    directed.push_back(op_row(ACT_LOOKUP, '0, '0, '1, 1, result_of(1, 0, 0, 0, 0, 0, 2)));
    directed.push_back(op_row(ACT_PUT, '0, 32'd5, 32'hA5A5_A5A5, 1,
                              result_of(0, 0, 0, 0, 0, 0, 2)));
    directed.push_back(op_row(ACT_LOOKUP, '0, 32'd5, '0, 1,
                              result_of(1, 0, 32'hA5A5_A5A5, 0, 0, 0, 2)));
    directed.push_back(op_row(ACT_PUT, 64'h1234_5678_9ABC_DEF0, 32'd1, 32'h0F0F_0F0F, 1,
                              result_of(0, 0, 0, 0, 0, 0, 3)));
    directed.push_back(cap_row(9'd1));
    directed.push_back(op_row(ACT_PUT, 64'h5555_5555_5555_5555, 32'd2, 32'd3, 0, '0));
    directed.push_back(op_row(ACT_TRIM, '0, '0, '0, 0, '0));
    directed.push_back(cap_row(9'd0));
    directed.push_back(op_row(ACT_TRIM, '1, '1, '1, 0, '0));
    directed.push_back(op_row(ACT_CLEAR, '1, '1, '1, 1, result_of(0, 0, 0, 0, 0, 0, 0)));
    directed.push_back(op_row(ACT_LOOKUP, 64'h5555_5555_5555_5555, 32'd2, '0, 1,
                              result_of(0, 0, 0, 0, 0, 0, 0)));
    directed.push_back(cap_row(9'd511));
    directed.push_back(op_row(ACT_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                              1, result_of(0, 0, 0, 0, 0, 0, 1)));
    directed.push_back(op_row(ACT_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, '0, 1,
                              result_of(0, 1, 0, 0, 0, 0, 1)));
    directed.push_back(op_row(ACT_TRIM, '0, '0, '0, 1, result_of(0, 0, 0, 0, 0, 0, 1)));
    directed.push_back(cap_row(9'd2));
    directed.push_back(op_row(ACT_PUT, 64'd1, 32'd7, 32'd11, 0, '0));
    directed.push_back(op_row(ACT_PUT, 64'd2, 32'd7, 32'd12, 0, '0));
    directed.push_back(op_row(ACT_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, '0, 0, '0));
    directed.push_back(op_row(ACT_CLEAR, '0, '0, '0, 1, result_of(0, 0, 0, 0, 0, 0, 0)));

    // Random phases: fill past the table size uncapped, then tighten the cap while
    // full so puts evict one each without growing and trims cut deep, then loosen again.
    phases[0] = '{9'd0,   IDLE_NONE, 450, 75, 3, 0};
    phases[1] = '{9'd256, IDLE_SEND, 250, 50, 4, 0};
    phases[2] = '{9'd100, IDLE_RECV, 250, 45, 5, 0};
    phases[3] = '{9'd1,   IDLE_BOTH, 150, 45, 5, 2};
    phases[4] = '{9'd300, IDLE_RECV, 250, 55, 5, 1};
    phases[5] = '{9'd255, IDLE_SEND, 230, 50, 5, 1};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        // the table must be quiet before the capacity changes
        wait_results_done();
        write_capacity(directed[i].cap);
      end else begin
        send_request(directed[i].item, directed[i].typed, directed[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results_done();
      write_capacity(phases[p].cap);
      case (phases[p].mode)
        IDLE_NONE: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        IDLE_SEND: begin
          send_idle_pct = 83;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      for (int n = 0; n < phases[p].items; n++) begin
        // hold off the sender once mid-phase until the pipe is empty
        if (phases[p].mode == IDLE_SEND && n == phases[p].items / 2) wait_results_done();
        send_request(random_request(phases[p].put_pct, phases[p].trim_pct,
                                    phases[p].clear_pct), 1'b0, '0);
      end
    end

    // Drain, then idle a full sweep to catch any stray beat.
    wait_results_done();
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
